// ===== design/issu_pkg.sv =====
`default_nettype none

package issu_pkg;

	localparam int SITE_W       = 16;
	localparam int SIDE_W       = 9;
	localparam int MODE_W       = 2;
	localparam int CMD_W        = 2;
	localparam int TIDX_W       = 4;
	localparam int THR_W        = 33;
	localparam int RND_W        = 32;
	localparam int SUM_W        = 4;
	localparam int MAX_SIDE_DEF = 256;
	localparam int SIDE_RESET   = 16;
	localparam int TABLE_DEPTH  = 10;
	localparam int NBR_W        = 20;
	localparam int OFS_W        = 5;
	localparam int WORD_W       = 2 ** OFS_W;
	localparam int DIV_BITS     = 2;
	localparam int DIV_STEPS    = SITE_W / DIV_BITS;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int NCNT_W       = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int REG_IDX_W    = 4;
	localparam int CFG_DATA_W   = SIDE_W;

	localparam logic [REG_IDX_W-1:0] REG_SIDE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MODE = REG_IDX_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_SPIN  = 2'd0,
		CMD_WRITE_TABLE = 2'd1,
		CMD_UPDATE      = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_METROPOLIS = 2'd0,
		MODE_MULTI_HIT  = 2'd1,
		MODE_HEAT_BATH  = 2'd2,
		MODE_NONE       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_PREP,
		F_DIV,
		F_ADDR
	} f_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_RD0,
		B_RD1,
		B_RD2,
		B_EVAL,
		B_COMMIT
	} b_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SITE_W-1:0] site;
		logic              spin_value;
		logic [TIDX_W-1:0] table_index;
		logic [THR_W-1:0]  threshold;
		logic [RND_W-1:0]  random_fraction;
		logic              proposed_spin;
	} in_word_t;

	typedef struct packed {
		logic [SITE_W-1:0]        out_site;
		logic                     spin_now;
		logic                     changed;
		logic signed [SUM_W-1:0]  neighbour_sum;
	} out_word_t;

	typedef struct packed {
		in_word_t         item;
		logic             in_range;
		logic [NBR_W-1:0] up;
		logic [NBR_W-1:0] down;
		logic [NBR_W-1:0] left;
		logic [NBR_W-1:0] right;
	} job_t;

endpackage

`default_nettype wire

// ===== design/issu_fifo.sv =====
`default_nettype none

module issu_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = issu_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     store_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/issu_front.sv =====
`default_nettype none

module issu_front #(
	parameter int MAX_SIDE = issu_pkg::MAX_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire issu_pkg::in_word_t            item,
	output logic                               full,
	input  wire logic [issu_pkg::SIDE_W-1:0]   side,
	input  wire logic                          clearing,
	output issu_pkg::job_t                     job,
	output logic                               job_push,
	input  wire logic                          job_full
);

	localparam int SIDE_TOP = (2 ** issu_pkg::SIDE_W) - 1;
	localparam int N_CAP    = (MAX_SIDE > SIDE_TOP) ? SIDE_TOP : MAX_SIDE;

	issu_pkg::f_state_t                 state_q;
	issu_pkg::f_state_t                 state_d;
	issu_pkg::in_word_t                 item_q;
	logic [issu_pkg::SIDE_W-1:0]        n_q;
	logic [issu_pkg::SIDE_W-1:0]        n_clamp;
	logic [issu_pkg::NBR_W-1:0]         nn_q;
	logic [issu_pkg::NBR_W-1:0]         nnm_q;
	logic [issu_pkg::SIDE_W-1:0]        rem_q;
	logic [issu_pkg::SIDE_W-1:0]        rem_d;
	logic [issu_pkg::SITE_W-1:0]        dvd_q;
	logic [issu_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               take;
	logic [issu_pkg::NBR_W-1:0]         site_x;
	logic [issu_pkg::NBR_W-1:0]         n_x;
	logic [issu_pkg::NBR_W-1:0]         col_x;

	assign take = (state_q == issu_pkg::F_IDLE) && push && !clearing;
	assign full = clearing || (state_q != issu_pkg::F_IDLE);

	always_comb begin
		if (side < issu_pkg::SIDE_W'(2)) begin
			n_clamp = issu_pkg::SIDE_W'(2);
		end else if (int'(side) > N_CAP) begin
			n_clamp = issu_pkg::SIDE_W'(N_CAP);
		end else begin
			n_clamp = side;
		end
	end

	// two restoring remainder steps per cycle
	always_comb begin
		logic [issu_pkg::SIDE_W:0]   trial;
		logic [issu_pkg::SIDE_W-1:0] r;
		r     = rem_q;
		trial = '0;
		for (int i = 0; i < issu_pkg::DIV_BITS; i++) begin
			trial = {r, dvd_q[issu_pkg::SITE_W-1-i]};
			if (trial >= {1'b0, n_q}) begin
				trial = trial - {1'b0, n_q};
			end
			r = trial[issu_pkg::SIDE_W-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= issu_pkg::F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == issu_pkg::F_PREP) begin
				cnt_q <= '0;
			end else if (state_q == issu_pkg::F_DIV) begin
				cnt_q <= cnt_q + issu_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		job_push = 1'b0;
		case (state_q)
			issu_pkg::F_IDLE: begin
				if (take) begin
					state_d = issu_pkg::F_PREP;
				end
			end
			issu_pkg::F_PREP: begin
				state_d = issu_pkg::F_DIV;
			end
			issu_pkg::F_DIV: begin
				if (cnt_q == issu_pkg::DIV_CNT_W'(issu_pkg::DIV_STEPS - 1)) begin
					state_d = issu_pkg::F_ADDR;
				end
			end
			issu_pkg::F_ADDR: begin
				if (!job_full) begin
					job_push = 1'b1;
					state_d  = issu_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = issu_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
		end
		if (state_q == issu_pkg::F_PREP) begin
			n_q   <= n_clamp;
			rem_q <= '0;
			dvd_q <= item_q.site;
		end
		if (state_q == issu_pkg::F_DIV) begin
			rem_q <= rem_d;
			dvd_q <= dvd_q << issu_pkg::DIV_BITS;
			nn_q  <= issu_pkg::NBR_W'(n_q) * issu_pkg::NBR_W'(n_q);
			nnm_q <= issu_pkg::NBR_W'(n_q) * (issu_pkg::NBR_W'(n_q) - issu_pkg::NBR_W'(1));
		end
	end

	assign site_x = issu_pkg::NBR_W'(item_q.site);
	assign n_x    = issu_pkg::NBR_W'(n_q);
	assign col_x  = issu_pkg::NBR_W'(rem_q);

	always_comb begin
		job.item     = item_q;
		job.in_range = (site_x < nn_q);
		job.up       = (site_x < n_x) ? site_x + nnm_q : site_x - n_x;
		job.down     = (site_x >= nnm_q) ? site_x - nnm_q : site_x + n_x;
		job.right    = (col_x == n_x - issu_pkg::NBR_W'(1))
			? site_x - n_x + issu_pkg::NBR_W'(1) : site_x + issu_pkg::NBR_W'(1);
		job.left     = (col_x == '0)
			? site_x + n_x - issu_pkg::NBR_W'(1) : site_x - issu_pkg::NBR_W'(1);
	end

endmodule

`default_nettype wire

// ===== design/issu_back.sv =====
`default_nettype none

module issu_back #(
	parameter int MAX_SIDE = issu_pkg::MAX_SIDE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [issu_pkg::MODE_W-1:0] mode,
	input  wire issu_pkg::job_t              job,
	input  wire logic                        job_empty,
	output logic                             job_pop,
	output issu_pkg::out_word_t              res,
	output logic                             res_push,
	input  wire logic                        res_full,
	output logic                             clearing
);

	localparam int SITES  = MAX_SIDE * MAX_SIDE;
	localparam int LAT_AW = $clog2(SITES);
	localparam int ADDR_W = (LAT_AW > issu_pkg::OFS_W) ? LAT_AW : issu_pkg::OFS_W + 1;
	localparam int WA_W   = ADDR_W - issu_pkg::OFS_W;

	issu_pkg::b_state_t                  state_q;
	issu_pkg::b_state_t                  state_d;
	issu_pkg::job_t                      job_q;
	logic [issu_pkg::WORD_W-1:0]         mem [2 ** WA_W];
	logic [issu_pkg::WORD_W-1:0]         rd_a_q;
	logic [issu_pkg::WORD_W-1:0]         rd_b_q;
	logic [WA_W-1:0]                     ra;
	logic [WA_W-1:0]                     rb;
	logic                                we;
	logic [WA_W-1:0]                     wa;
	logic [issu_pkg::WORD_W-1:0]         wd;
	logic [WA_W-1:0]                     clr_q;
	logic [issu_pkg::WORD_W-1:0]         self_word_q;
	logic                                up_q;
	logic                                down_q;
	logic                                left_q;
	logic [issu_pkg::THR_W-1:0]          table_q [issu_pkg::TABLE_DEPTH];
	logic [issu_pkg::THR_W-1:0]          t_q;
	logic [issu_pkg::SUM_W-1:0]          sum_q;
	logic [issu_pkg::NBR_W-1:0]          self_addr;
	logic [issu_pkg::OFS_W-1:0]          self_ofs;
	logic                                spin_old;
	logic                                right_bit;
	logic [issu_pkg::NCNT_W-1:0]         ones;
	logic [issu_pkg::TIDX_W-1:0]         tidx;
	logic                                pass;
	logic                                after;
	logic                                commit;

	assign self_addr = issu_pkg::NBR_W'(job_q.item.site);
	assign self_ofs  = self_addr[issu_pkg::OFS_W-1:0];
	assign spin_old  = self_word_q[self_ofs];
	assign right_bit = rd_a_q[job_q.right[issu_pkg::OFS_W-1:0]];
	assign clearing  = (state_q == issu_pkg::B_CLEAR);
	assign commit    = (state_q == issu_pkg::B_COMMIT) && !res_full;

	always_comb begin
		ones = issu_pkg::NCNT_W'(up_q) + issu_pkg::NCNT_W'(down_q)
			+ issu_pkg::NCNT_W'(left_q) + issu_pkg::NCNT_W'(right_bit);
		tidx = spin_old ? issu_pkg::TIDX_W'(ones) + issu_pkg::TIDX_W'(5)
			: issu_pkg::TIDX_W'(ones);
	end

	always_comb begin
		pass  = {1'b0, job_q.item.random_fraction} < t_q;
		after = spin_old;
		case (job_q.item.command)
			issu_pkg::CMD_WRITE_SPIN: begin
				after = job_q.item.spin_value;
			end
			issu_pkg::CMD_UPDATE: begin
				case (mode)
					issu_pkg::MODE_METROPOLIS: after = pass ? !spin_old : spin_old;
					issu_pkg::MODE_MULTI_HIT: begin
						if (job_q.item.proposed_spin != spin_old && pass) begin
							after = job_q.item.proposed_spin;
						end
					end
					issu_pkg::MODE_HEAT_BATH: after = pass;
					default: after = spin_old;
				endcase
			end
			default: after = spin_old;
		endcase
	end

	always_comb begin
		res.out_site      = job_q.item.site;
		res.spin_now      = job_q.in_range && after;
		res.changed       = job_q.in_range && (after != spin_old);
		res.neighbour_sum = job_q.in_range ? sum_q : '0;
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		ra       = self_addr[ADDR_W-1:issu_pkg::OFS_W];
		rb       = job_q.up[ADDR_W-1:issu_pkg::OFS_W];
		we       = 1'b0;
		wa       = self_addr[ADDR_W-1:issu_pkg::OFS_W];
		wd       = self_word_q;
		wd[self_ofs] = after;
		case (state_q)
			issu_pkg::B_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '1;
				if (clr_q == '1) begin
					state_d = issu_pkg::B_IDLE;
				end
			end
			issu_pkg::B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = issu_pkg::B_RD0;
				end
			end
			issu_pkg::B_RD0: begin
				state_d = issu_pkg::B_RD1;
			end
			issu_pkg::B_RD1: begin
				ra      = job_q.down[ADDR_W-1:issu_pkg::OFS_W];
				rb      = job_q.left[ADDR_W-1:issu_pkg::OFS_W];
				state_d = issu_pkg::B_RD2;
			end
			issu_pkg::B_RD2: begin
				ra      = job_q.right[ADDR_W-1:issu_pkg::OFS_W];
				state_d = issu_pkg::B_EVAL;
			end
			issu_pkg::B_EVAL: begin
				state_d = issu_pkg::B_COMMIT;
			end
			issu_pkg::B_COMMIT: begin
				if (!res_full) begin
					res_push = 1'b1;
					we       = job_q.in_range;
					state_d  = issu_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = issu_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= issu_pkg::B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == issu_pkg::B_CLEAR) begin
				clr_q <= clr_q + WA_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == issu_pkg::B_RD1) begin
			self_word_q <= rd_a_q;
			up_q        <= rd_b_q[job_q.up[issu_pkg::OFS_W-1:0]];
		end
		if (state_q == issu_pkg::B_RD2) begin
			down_q <= rd_a_q[job_q.down[issu_pkg::OFS_W-1:0]];
			left_q <= rd_b_q[job_q.left[issu_pkg::OFS_W-1:0]];
		end
		if (state_q == issu_pkg::B_EVAL) begin
			sum_q <= {ones, 1'b0} - issu_pkg::SUM_W'(4);
			t_q   <= table_q[tidx];
		end
		if (commit && job_q.item.command == issu_pkg::CMD_WRITE_TABLE
			&& job_q.item.table_index < issu_pkg::TIDX_W'(issu_pkg::TABLE_DEPTH)) begin
			table_q[job_q.item.table_index] <= job_q.item.threshold;
		end
	end

endmodule

`default_nettype wire

// ===== design/ising_spin_site_update_core.sv =====
// Periodic square Ising lattice of one-bit spins with a ten-entry threshold table; each input
// word writes a spin, writes a table entry, updates a site (Metropolis, multi-hit try, heat
// bath or no change, set by the mode register) or reads a site, and yields exactly one result
// word. After reset the lattice is swept to all +1, one 32-spin memory row per cycle; full
// stays high until the sweep ends, while configuration writes are taken at any time. The front
// end takes one item at a time: it loads the side, runs eight radix-4 steps of the
// site-modulo-side remainder unit, forms the neighbour addresses and pushes the job, then
// returns to accept the next. The back end works on one job at a time on the two-read-port
// lattice memory (three read states, evaluate, commit). A job queue and a result queue, two
// words each, let either side stall on its own.
`default_nettype none

module ising_spin_site_update_core #(
	parameter int MAX_SIDE = issu_pkg::MAX_SIDE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire issu_pkg::in_word_t              item,
	output logic                                 empty,
	input  wire logic                            pop,
	output issu_pkg::out_word_t                  result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [issu_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [issu_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int JOB_W = $bits(issu_pkg::job_t);
	localparam int RES_W = $bits(issu_pkg::out_word_t);

	logic [issu_pkg::SIDE_W-1:0] side_q;
	logic [issu_pkg::MODE_W-1:0] mode_q;
	issu_pkg::job_t              job_in;
	issu_pkg::job_t              job_out;
	logic                        job_push;
	logic                        job_full;
	logic                        job_pop;
	logic                        job_empty;
	issu_pkg::out_word_t         res_in;
	logic                        res_push;
	logic                        res_full;
	logic                        clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= issu_pkg::SIDE_W'(issu_pkg::SIDE_RESET);
			mode_q <= issu_pkg::MODE_METROPOLIS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				issu_pkg::REG_SIDE: side_q <= cfg_data[issu_pkg::SIDE_W-1:0];
				issu_pkg::REG_MODE: mode_q <= cfg_data[issu_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	issu_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.side     (side_q),
		.clearing (clearing),
		.job      (job_in),
		.job_push (job_push),
		.job_full (job_full)
	);

	issu_fifo #(
		.W     (JOB_W),
		.DEPTH (issu_pkg::QUEUE_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	issu_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full),
		.clearing  (clearing)
	);

	issu_fifo #(
		.W     (RES_W),
		.DEPTH (issu_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

// ===== tb/sv/ising_spin_site_update_core_checker.sv =====
`timescale 1ns / 1ps

module ising_spin_site_update_core_checker
	import issu_pkg::*;
#(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  in_word_t              item,
	input  logic                  empty,
	input  logic                  pop,
	input  out_word_t             result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    compared,
	output int                    spin_changes
);

	bit               spins [MAX_SIDE*MAX_SIDE];
	logic [THR_W-1:0] thresholds [TABLE_DEPTH];
	logic [SIDE_W-1:0] side_reg;
	mode_t            mode_reg;
	out_word_t        site_results [$];
	out_word_t        want;

	task automatic report(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic out_word_t step_site(input in_word_t w);
		int unsigned n, row, col, up, down, left, right, tidx;
		int          nsum;
		bit          was, hit;
		out_word_t   r;
		n = side_reg < 2 ? 2 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
		r = '0;
		r.out_site = w.site;
		if (w.site >= n * n) begin
			if (cmd_t'(w.command) == CMD_WRITE_TABLE && w.table_index < TABLE_DEPTH)
				thresholds[w.table_index] = w.threshold;
			return r;
		end
		row   = w.site / n;
		col   = w.site % n;
		up    = (row == 0)     ? w.site + n * (n - 1) : w.site - n;
		down  = (row == n - 1) ? w.site - n * (n - 1) : w.site + n;
		right = (col == n - 1) ? w.site - n + 1       : w.site + 1;
		left  = (col == 0)     ? w.site + n - 1       : w.site - 1;
		nsum  = (spins[up] ? 1 : -1) + (spins[right] ? 1 : -1)
		      + (spins[down] ? 1 : -1) + (spins[left] ? 1 : -1);
		was = spins[w.site];
		case (cmd_t'(w.command))
			CMD_WRITE_SPIN: spins[w.site] = w.spin_value;
			CMD_WRITE_TABLE: begin
				if (w.table_index < TABLE_DEPTH)
					thresholds[w.table_index] = w.threshold;
			end
			CMD_UPDATE: begin
				tidx = (was ? 5 : 0) + (nsum + 4) / 2;
				hit  = w.random_fraction < thresholds[tidx];
				case (mode_reg)
					MODE_METROPOLIS: if (hit) spins[w.site] = !was;
					MODE_MULTI_HIT: begin
						if (w.proposed_spin != was && hit)
							spins[w.site] = w.proposed_spin;
					end
					MODE_HEAT_BATH: spins[w.site] = hit;
					default: ;
				endcase
			end
			default: ;
		endcase
		r.spin_now      = spins[w.site];
		r.changed       = spins[w.site] != was;
		r.neighbour_sum = SUM_W'(nsum);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (spins[i]) spins[i] = 1'b1;
			foreach (thresholds[i]) thresholds[i] = '0;
			side_reg = SIDE_W'(SIDE_RESET);
			mode_reg = MODE_METROPOLIS;
			site_results.delete();
			mismatches   = 0;
			pending      = 0;
			compared     = 0;
			spin_changes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SIDE)
					side_reg = cfg_data[SIDE_W-1:0];
				else if (cfg_index == REG_MODE)
					mode_reg = mode_t'(cfg_data[MODE_W-1:0]);
			end
			if (pop && !empty) begin
				if (site_results.size() == 0) begin
					report($sformatf("word for site %0d with none expected", result.out_site));
				end else begin
					want = site_results.pop_front();
					compared++;
					if (result.out_site !== want.out_site)
						report($sformatf("out_site %0d, want %0d", result.out_site,
							want.out_site));
					if (result.spin_now !== want.spin_now)
						report($sformatf("site %0d: spin_now %b, want %b", want.out_site,
							result.spin_now, want.spin_now));
					if (result.changed !== want.changed)
						report($sformatf("site %0d: changed %b, want %b", want.out_site,
							result.changed, want.changed));
					if (result.neighbour_sum !== want.neighbour_sum)
						report($sformatf("site %0d: neighbour_sum %0d, want %0d",
							want.out_site, result.neighbour_sum, want.neighbour_sum));
				end
			end
			if (push && !full) begin
				want = step_site(item);
				if (want.changed)
					spin_changes++;
				site_results.insert(site_results.size(), want);
			end
			pending = site_results.size();
		end
	end

endmodule

// ===== tb/sv/ising_spin_site_update_core_test.sv =====
`timescale 1ns / 1ps

module ising_spin_site_update_core_test;
	import issu_pkg::*;

	localparam int PHASES       = 9;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 2_000_000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_word_t              item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_word_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index = REG_SIDE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  holding   = 1'b0;
	int                    send_idle = 30;
	int                    recv_idle = 84;
	int unsigned           words_sent = 0;
	int                    mismatches, pending, compared, spin_changes;
	event                  hold_results;

	int unsigned phase_side  [PHASES] = '{2, 256, 5, 0, 511, 16, 7, 300, 1};
	mode_t       phase_mode  [PHASES] = '{MODE_METROPOLIS, MODE_MULTI_HIT, MODE_HEAT_BATH,
		MODE_NONE, MODE_HEAT_BATH, MODE_METROPOLIS, MODE_MULTI_HIT, MODE_HEAT_BATH,
		MODE_METROPOLIS};
	int unsigned phase_words [PHASES] = '{150, 250, 200, 100, 200, 300, 250, 150, 150};

	always #1 clk = ~clk;

	ising_spin_site_update_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ising_spin_site_update_core_checker lattice_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.compared     (compared),
		.spin_changes (spin_changes)
	);

	always @(posedge clk) begin
		if (!arst_n || holding)
			pop <= 1'b0;
		else
			pop <= $urandom_range(0, 99) >= recv_idle;
	end

	// hold results back so the block fills and stalls its input
	initial forever begin
		@(hold_results);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d words still owed", pending);
		$display("Test completed with failures");
		$finish;
	end

	function automatic in_word_t word_of(input cmd_t cmd, input int unsigned site,
		input logic spin, input int unsigned tidx, input logic [THR_W-1:0] thr,
		input logic [RND_W-1:0] rnd, input logic prop);
		in_word_t w;
		w.command         = cmd;
		w.site            = SITE_W'(site);
		w.spin_value      = spin;
		w.table_index     = TIDX_W'(tidx);
		w.threshold       = thr;
		w.random_fraction = rnd;
		w.proposed_spin   = prop;
		return w;
	endfunction

	function automatic in_word_t random_word(input int unsigned n);
		in_word_t    w;
		int unsigned pick, sites;
		sites = n * n;
		pick  = $urandom_range(0, 99);
		w.spin_value      = 1'($urandom_range(0, 1));
		w.table_index     = TIDX_W'($urandom_range(0, 15));
		w.threshold       = {1'($urandom_range(0, 1)), 32'($urandom())};
		w.random_fraction = $urandom();
		w.proposed_spin   = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 15))
			0: w.random_fraction = '0;
			1: w.random_fraction = '1;
			default: ;
		endcase
		if (pick < 58) begin
			w.command = CMD_UPDATE;
		end else if (pick < 72) begin
			w.command = CMD_WRITE_SPIN;
		end else if (pick < 86) begin
			w.command = CMD_READ;
		end else begin
			w.command = CMD_WRITE_TABLE;
			if ($urandom_range(0, 7) != 0)
				w.table_index = TIDX_W'($urandom_range(0, TABLE_DEPTH - 1));
			case ($urandom_range(0, 3))
				0: w.threshold = 33'h1_0000_0000;
				1: w.threshold = '0;
				2: w.threshold = {1'b0, 32'($urandom())};
				default: ;
			endcase
		end
		if (sites < 65536 && $urandom_range(0, 11) == 0)
			w.site = SITE_W'($urandom_range(sites, 65535));
		else
			w.site = SITE_W'($urandom_range(0, sites - 1));
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		logic taken;
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		words_sent++;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the whole table before any update reads it
		send_word(word_of(CMD_WRITE_TABLE, 0, 1'b0, 0, 33'h1_0000_0000, '0, 1'b0));
		send_word(word_of(CMD_WRITE_TABLE, 65535, 1'b1, 1, 33'h1_FFFF_FFFF, '1, 1'b1));
		send_word(word_of(CMD_WRITE_TABLE, 100, 1'b0, 2, 33'h0_8000_0000, '0, 1'b0));
		send_word(word_of(CMD_WRITE_TABLE, 101, 1'b1, 3, 33'h0, '1, 1'b1));
		send_word(word_of(CMD_WRITE_TABLE, 102, 1'b0, 4, 33'h0_FFFF_FFFF, '0, 1'b0));
		send_word(word_of(CMD_WRITE_TABLE, 103, 1'b1, 5, 33'h1_0000_0000, '1, 1'b1));
		send_word(word_of(CMD_WRITE_TABLE, 104, 1'b0, 6, 33'h0, '0, 1'b0));
		send_word(word_of(CMD_WRITE_TABLE, 105, 1'b1, 7, 33'h0_4000_0000, '1, 1'b1));
		send_word(word_of(CMD_WRITE_TABLE, 106, 1'b0, 8, 33'h0, '0, 1'b0));
		send_word(word_of(CMD_WRITE_TABLE, 255, 1'b1, 9, 33'h0_0000_0001, '1, 1'b1));
		send_word(word_of(CMD_WRITE_TABLE, 17, 1'b0, 15, 33'h0, '0, 1'b0));
		send_word(word_of(CMD_WRITE_SPIN, 0, 1'b0, 0, '0, '0, 1'b0));
		send_word(word_of(CMD_UPDATE, 0, 1'b0, 0, '0, '0, 1'b1));
		send_word(word_of(CMD_UPDATE, 255, 1'b1, 9, '1, '1, 1'b0));
		send_word(word_of(CMD_WRITE_SPIN, 1, 1'b0, 1, '0, '0, 1'b0));
		send_word(word_of(CMD_UPDATE, 17, 1'b0, 2, '0, 32'h7FFF_FFFF, 1'b0));
		send_word(word_of(CMD_UPDATE, 1, 1'b1, 3, '0, '0, 1'b1));
		send_word(word_of(CMD_READ, 255, 1'b0, 4, '0, '0, 1'b0));
		send_word(word_of(CMD_READ, 256, 1'b1, 5, '1, '1, 1'b1));
		send_word(word_of(CMD_READ, 65535, 1'b1, 15, '1, '1, 1'b1));
		send_word(word_of(CMD_WRITE_SPIN, 300, 1'b0, 0, '0, '0, 1'b0));
		send_word(word_of(CMD_UPDATE, 40000, 1'b0, 0, '0, '0, 1'b1));
		send_word(word_of(CMD_UPDATE, 15, 1'b1, 0, '0, 32'h7FFF_FFFF, 1'b0));
		send_word(word_of(CMD_UPDATE, 240, 1'b0, 0, '0, 32'h0000_0001, 1'b1));
		push <= 1'b0;
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_SIDE, CFG_DATA_W'(phase_side[p]));
			write_reg(REG_MODE, CFG_DATA_W'(phase_mode[p]));
			n = phase_side[p] < 2 ? 2
				: (phase_side[p] > MAX_SIDE_DEF ? MAX_SIDE_DEF : phase_side[p]);
			send_idle = p < 3 ? 30 : (p < 6 ? 84 : 0);
			recv_idle <= p < 3 ? 84 : (p < 6 ? 30 : 0);
			if (p == 0)
				-> hold_results;
			repeat (phase_words[p]) send_word(random_word(n));
			// drop push once the last word is taken, then wait for every result
			push <= 1'b0;
			wait_drained();
		end

		$display("Sent %0d words: directed corners, then %0d lattice sides and modes,",
			words_sent, PHASES);
		$display("clamped sides and the unused mode included; %0d results compared, %0d spin changes.",
			compared, spin_changes);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
